// ----- sv/pwmt_pkg.sv -----
// ----------------------------------------------------------------------------
// pwmt_pkg
// Shared types, codes and helpers of the pulse width meter with timeout.
// ----------------------------------------------------------------------------
package pwmt_pkg;

  localparam int unsigned TimeBits = 16;
  // common width for comparing time counters with 16-bit quantities
  localparam int unsigned CmpBits = (TimeBits > 16) ? TimeBits : 16;

  typedef logic [TimeBits-1:0] time_t;

  localparam logic [7:0]  TicksPerUsRst    = 8'd72;
  localparam logic [15:0] TimeoutUsRst     = 16'd2000;
  localparam logic [7:0]  MinWidthTicksRst = 8'd30;
  localparam logic [7:0]  PulseTicksMax    = 8'hFF;
  localparam logic [15:0] WidthMax         = 16'hFFFF;

  localparam logic ReqTick  = 1'b0;
  localparam logic ReqStart = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_RISE,
    PH_PULSE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TO_HIGH,
    ST_TO_RISE,
    ST_TO_PULSE
  } status_e;

  typedef enum logic [1:0] {
    CFG_TICKS_PER_US,
    CFG_TIMEOUT_US,
    CFG_MIN_WIDTH_TICKS
  } cfg_idx_e;

  typedef struct packed {
    logic req_type;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] width_us;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [15:0] timeout_us;
    logic [7:0]  min_width_ticks;
  } cfg_t;

  // microsecond counter with its tick prescaler
  typedef struct packed {
    time_t      us;
    logic [7:0] pre;
  } usc_t;

  function automatic usc_t usc_advance(usc_t c, logic [7:0] div);
    logic [8:0] p;
    usc_t       r;
    p = {1'b0, c.pre} + 9'd1;
    r = c;
    if (p >= {1'b0, div}) begin
      r.pre = '0;
      if (c.us != {TimeBits{1'b1}}) begin
        r.us = c.us + time_t'(1);
      end
    end else begin
      r.pre = p[7:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/pwmt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pwmt_cfg_regs
// Configuration registers of the pulse width meter, write only.
// ----------------------------------------------------------------------------
module pwmt_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i,
  output pwmt_pkg::cfg_t   cfg_o
);
  import pwmt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TICKS_PER_US:    cfg_d.ticks_per_us    = cfg_wdata_i[7:0];
        CFG_TIMEOUT_US:      cfg_d.timeout_us      = cfg_wdata_i;
        CFG_MIN_WIDTH_TICKS: cfg_d.min_width_ticks = cfg_wdata_i[7:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us    <= TicksPerUsRst;
      cfg_q.timeout_us      <= TimeoutUsRst;
      cfg_q.min_width_ticks <= MinWidthTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/pulse_width_meter_with_timeout.sv -----
// ----------------------------------------------------------------------------
// pulse_width_meter_with_timeout
// Measures one high pulse on a sampled pin after a start request, with an
// overall timeout and a status naming the phase in which it ran out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  in        input      in_valid_i / in_stall_o       in_data_i  (req_type, pin_level)
//  out       output     out_valid_o / out_stall_i     out_data_o (status, width_us)
//  cfg       input      cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
//  one item per clock unless a held result stalls the input; an item is
//  registered and processed once the result register is free, which holds its result
//  the state update is two prescaled counters, a saturating tick count and
//  16-bit compares per item
//  in_stall_o rises only while a result waits, out_stall_i is high and an
//  item sits in the input register
//  reset clears phase and counters and loads the register defaults
// ----------------------------------------------------------------------------
module pulse_width_meter_with_timeout (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pwmt_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pwmt_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);
  import pwmt_pkg::*;

  cfg_t       cfg;
  logic [7:0] div;

  logic       s1_valid_q, s1_valid_d;
  in_item_t   s1_item_q;
  logic       out_free, in_fire, proc;

  phase_e     phase_q, phase_d;
  usc_t       elapsed_q, elapsed_d, elapsed_adv;
  usc_t       pulse_q, pulse_d, pulse_adv;
  logic [7:0] pulse_ticks_q, pulse_ticks_d, pulse_ticks_adv;
  logic       timed_out, active_tick, enter_pulse;
  logic       done;
  out_item_t  res;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;

  pwmt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign div = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign proc       = s1_valid_q && out_free;

  assign s1_valid_d = in_fire || (s1_valid_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
  end

  // time counters advanced by this tick
  assign active_tick = proc && (s1_item_q.req_type == ReqTick) && (phase_q != PH_IDLE);
  assign elapsed_adv = usc_advance(elapsed_q, div);
  assign pulse_adv   = (phase_q == PH_PULSE) ? usc_advance(pulse_q, div) : pulse_q;
  assign pulse_ticks_adv = ((phase_q == PH_PULSE) && (pulse_ticks_q != PulseTicksMax)) ?
                           pulse_ticks_q + 8'd1 : pulse_ticks_q;
  assign timed_out = CmpBits'(elapsed_adv.us) >= CmpBits'(cfg.timeout_us);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (proc && (s1_item_q.req_type == ReqStart)) begin
      phase_d = PH_HIGH;
    end else if (active_tick) begin
      unique case (phase_q)
        PH_HIGH:  phase_d = s1_item_q.pin_level ? PH_HIGH : PH_RISE;
        PH_RISE:  phase_d = s1_item_q.pin_level ? PH_PULSE : PH_RISE;
        PH_PULSE: phase_d = PH_PULSE;
        default:  phase_d = phase_q;
      endcase
      if (done) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // finish decision and result
  always_comb begin
    done          = 1'b0;
    enter_pulse   = 1'b0;
    res.status    = ST_OK;
    res.width_us  = '0;
    if (active_tick) begin
      unique case (phase_q)
        PH_HIGH: begin
          if (timed_out) begin
            done       = 1'b1;
            res.status = s1_item_q.pin_level ? ST_TO_HIGH : ST_TO_RISE;
          end
        end
        PH_RISE: begin
          enter_pulse = s1_item_q.pin_level;
          if (timed_out) begin
            done       = 1'b1;
            res.status = s1_item_q.pin_level ? ST_TO_PULSE : ST_TO_RISE;
          end
        end
        PH_PULSE: begin
          if (s1_item_q.pin_level) begin
            if (timed_out) begin
              done       = 1'b1;
              res.status = ST_TO_PULSE;
            end
          end else begin
            done = 1'b1;
            if (pulse_ticks_adv < cfg.min_width_ticks) begin
              res.width_us = '0;
            end else if (CmpBits'(pulse_adv.us) > CmpBits'(WidthMax)) begin
              res.width_us = WidthMax;
            end else begin
              res.width_us = 16'(CmpBits'(pulse_adv.us));
            end
          end
        end
        default: done = 1'b0;
      endcase
    end
  end

  // counter updates
  always_comb begin
    elapsed_d     = elapsed_q;
    pulse_d       = pulse_q;
    pulse_ticks_d = pulse_ticks_q;
    if (proc && (s1_item_q.req_type == ReqStart)) begin
      elapsed_d     = '0;
      pulse_d       = '0;
      pulse_ticks_d = '0;
    end else if (active_tick) begin
      if (done) begin
        elapsed_d     = '0;
        pulse_d       = '0;
        pulse_ticks_d = '0;
      end else if (enter_pulse) begin
        elapsed_d     = elapsed_adv;
        pulse_d       = '0;
        pulse_ticks_d = '0;
      end else begin
        elapsed_d     = elapsed_adv;
        pulse_d       = pulse_adv;
        pulse_ticks_d = pulse_ticks_adv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      elapsed_q     <= '0;
      pulse_q       <= '0;
      pulse_ticks_q <= '0;
    end else begin
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      pulse_q       <= pulse_d;
      pulse_ticks_q <= pulse_ticks_d;
    end
  end

  // result register
  assign out_valid_d = (proc && done) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && done) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a result only comes from a running measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && done) |-> (phase_q != PH_IDLE))
    else $error("result produced while idle");

  // a finished measurement leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && done) |=> (phase_q == PH_IDLE))
    else $error("phase not idle after result");

  // timeouts carry no width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |-> (out_q.width_us == 16'd0))
    else $error("nonzero width with timeout status");

  // pulse tick count only runs inside a pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_PULSE) |-> (pulse_ticks_q == 8'd0))
    else $error("pulse ticks counted outside pulse");

  // a held result blocks the processing stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !proc)
    else $error("item processed while result stalled");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Feeds start and tick words into the pulse width meter and checks every
// result word against a cycle-free predictor of the measurement. A short
// directed table comes first, then random measurements under several
// register settings, then one long pulse. Both channels idle and stall at
// random, and the receiver holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmt_pkg::*;

  localparam int unsigned HalfPeriod     = 4;
  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned NumRows        = 30;
  localparam int unsigned RandomItems    = 1600;
  localparam int unsigned NumSettings    = 8;
  localparam int unsigned LongPulseTicks = 300;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned SettleCycles   = 6;
  localparam int unsigned CycleLimit     = 1500000;
  localparam int unsigned MaxReports     = 200;
  localparam logic [1:0]  CfgIdxSpare    = 2'd3;

  typedef struct packed {
    time_t      us;
    logic [7:0] frac;
  } us_count_t;

  typedef struct packed {
    logic        is_cfg;
    logic [7:0]  tpu;
    logic [15:0] tmo;
    logic [7:0]  mw;
    in_item_t    word;
    logic        typed;
    out_item_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_word;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  // predictor state and register copies
  phase_e      ph = PH_IDLE;
  us_count_t   since_start = '0;
  us_count_t   since_rise = '0;
  logic [7:0]  rise_ticks = '0;
  logic [7:0]  cur_tpu = TicksPerUsRst;
  logic [15:0] cur_tmo = TimeoutUsRst;
  logic [7:0]  cur_mw = MinWidthTicksRst;

  out_item_t   pending_results[$];
  int unsigned fail_count = 0;
  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  pulse_width_meter_with_timeout dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // one tick of a microsecond count; a divider of zero acts as one
  function automatic us_count_t bump(us_count_t c);
    us_count_t n;
    n = c;
    if ({1'b0, c.frac} + 9'd1 >= {1'b0, cur_tpu}) begin
      n.frac = '0;
      if (~&c.us) n.us = c.us + 1'b1;
    end else begin
      n.frac = c.frac + 8'd1;
    end
    return n;
  endfunction

  function automatic void clear_meter();
    ph = PH_IDLE;
    since_start = '0;
    since_rise = '0;
    rise_ticks = '0;
  endfunction

  function automatic bit measure_word(in_item_t w, output out_item_t res);
    logic        late;
    bit          fin;
    status_e     st;
    logic [15:0] wd;
    fin = 1'b0;
    st = ST_OK;
    wd = '0;
    res = '0;
    if (w.req_type == ReqStart) begin
      clear_meter();
      ph = PH_HIGH;
    end else if (ph != PH_IDLE) begin
      since_start = bump(since_start);
      if (ph == PH_PULSE) begin
        if (rise_ticks != PulseTicksMax) rise_ticks++;
        since_rise = bump(since_rise);
      end
      late = CmpBits'(since_start.us) >= CmpBits'(cur_tmo);
      if (ph == PH_HIGH) begin
        if (w.pin_level) begin
          fin = late;
          st = ST_TO_HIGH;
        end else begin
          ph = PH_RISE;
        end
      end
      // a low sample leaving the initial high is also judged as awaiting rise
      if (ph == PH_RISE) begin
        if (!w.pin_level) begin
          fin = late;
          st = ST_TO_RISE;
        end else begin
          ph = PH_PULSE;
          rise_ticks = '0;
          since_rise = '0;
          fin = late;
          st = ST_TO_PULSE;
        end
      end else if (ph == PH_PULSE) begin
        if (w.pin_level) begin
          fin = late;
          st = ST_TO_PULSE;
        end else begin
          fin = 1'b1;
          st = ST_OK;
          if (rise_ticks >= cur_mw) begin
            wd = (since_rise.us > WidthMax) ? WidthMax : since_rise.us[15:0];
          end
        end
      end
    end
    if (fin) begin
      res.status = st;
      res.width_us = wd;
      clear_meter();
    end
    return fin;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t word_of(logic req, logic pin);
    in_item_t w;
    w.req_type = req;
    w.pin_level = pin;
    return w;
  endfunction

  function automatic row_t cfg_row(logic [7:0] tpu, logic [15:0] tmo, logic [7:0] mw);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.tpu = tpu;
    r.tmo = tmo;
    r.mw = mw;
    return r;
  endfunction

  function automatic row_t item_row(logic req, logic pin);
    row_t r;
    r = '0;
    r.word = word_of(req, pin);
    return r;
  endfunction

  // errors and short pulses always report width zero
  function automatic row_t known_row(logic req, logic pin, status_e st);
    row_t r;
    r = item_row(req, pin);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.width_us = '0;
    return r;
  endfunction

  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    out_item_t res;
    bit        has;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sent_items++;
    has = measure_word(w, res);
    if (typed) begin
      has = 1'b1;
      res = want;
    end
    if (has) pending_results.push_back(res);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    int unsigned gap;
    int unsigned pick;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 94) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_run(logic req, logic pin, int unsigned n);
    repeat (n) begin
      send_word(word_of(req, pin), 1'b0, '0);
      pause_sender();
    end
  endtask

  // registers change only with nothing in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_regs(logic [7:0] tpu, logic [15:0] tmo, logic [7:0] mw);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_TICKS_PER_US;
    cfg_wdata <= {8'($urandom), tpu};
    @(negedge clk);
    cfg_idx <= CFG_TIMEOUT_US;
    cfg_wdata <= tmo;
    @(negedge clk);
    cfg_idx <= CFG_MIN_WIDTH_TICKS;
    cfg_wdata <= {8'($urandom), mw};
    @(negedge clk);
    // unmapped index must leave every register alone
    cfg_idx <= CfgIdxSpare;
    cfg_wdata <= 16'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_tpu = tpu;
    cur_tmo = tmo;
    cur_mw = mw;
  endtask

  task automatic run_measurement();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) begin
        send_run(($urandom_range(0, 3) == 0) ? ReqStart : ReqTick, 1'($urandom), 1);
      end
    end else begin
      send_run(ReqStart, 1'($urandom), 1);
      send_run(ReqTick, 1'b1,
               ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4));
      send_run(ReqTick, 1'b0,
               ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8));
      send_run(ReqTick, 1'b1,
               ($urandom_range(0, 4) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12));
      // some sequences never see the falling edge
      if (pick < 92) send_run(ReqTick, 1'b0, 1);
      if ($urandom_range(0, 6) == 0) send_run(ReqTick, 1'($urandom), $urandom_range(1, 3));
    end
  endtask

  initial begin : stimulus
    row_t        plan [NumRows];
    int unsigned mark;
    int unsigned span;
    logic [7:0]  tpu;
    logic [7:0]  mw;
    logic [15:0] tmo;
    plan = '{
      cfg_row(8'd2, 16'd10, 8'd3),
      item_row(ReqTick, 1'b1),            // tick while idle
      item_row(ReqStart, 1'b1),
      item_row(ReqTick, 1'b0),
      item_row(ReqTick, 1'b1),
      item_row(ReqTick, 1'b1),
      known_row(ReqTick, 1'b0, ST_OK),    // two ticks, below minimum
      item_row(ReqStart, 1'b0),
      item_row(ReqTick, 1'b1),
      item_row(ReqTick, 1'b0),
      item_row(ReqTick, 1'b1),
      item_row(ReqTick, 1'b1),
      item_row(ReqTick, 1'b1),
      item_row(ReqTick, 1'b1),
      item_row(ReqTick, 1'b0),
      cfg_row(8'd0, 16'd0, 8'd0),         // zero divider, zero timeout
      item_row(ReqStart, 1'b0),
      known_row(ReqTick, 1'b1, ST_TO_HIGH),
      item_row(ReqStart, 1'b1),
      known_row(ReqTick, 1'b0, ST_TO_RISE),
      cfg_row(8'd1, 16'd2, 8'd0),
      item_row(ReqStart, 1'b0),
      item_row(ReqTick, 1'b0),
      known_row(ReqTick, 1'b1, ST_TO_PULSE), // times out on the rising edge
      cfg_row(8'd255, 16'hFFFF, 8'd255),
      item_row(ReqStart, 1'b0),
      item_row(ReqStart, 1'b1),           // restart while busy
      item_row(ReqTick, 1'b0),
      item_row(ReqTick, 1'b1),
      known_row(ReqTick, 1'b0, ST_OK)
    };

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_regs(plan[i].tpu, plan[i].tmo, plan[i].mw);
      end else begin
        send_word(plan[i].word, plan[i].typed, plan[i].want);
        pause_sender();
      end
    end

    for (int s = 0; s < NumSettings; s++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       tpu = 8'd1;
        1:       tpu = 8'd255;
        default: tpu = 8'($urandom_range(2, 8));
      endcase
      span = $urandom_range(8, 120) / tpu;
      tmo = (span == 0) ? 16'd1 : 16'(span);
      if ($urandom_range(0, 9) == 0) tmo = 16'hFFFF;
      case ($urandom_range(0, 5))
        0:       mw = 8'd0;
        1:       mw = 8'd255;
        default: mw = 8'($urandom_range(1, 15));
      endcase
      write_regs(tpu, tmo, mw);
      if (s == 2) hold_req = 1'b1;
      mark = sent_items;
      while (sent_items - mark < RandomItems / NumSettings) run_measurement();
    end

    // one long pulse: saturates the tick count
    settle();
    write_regs(8'd1, 16'hFFFF, 8'($urandom));
    steady = 1'b1;
    send_run(ReqStart, 1'b0, 1);
    send_run(ReqTick, 1'b0, 1);
    send_run(ReqTick, 1'b1, LongPulseTicks);
    send_run(ReqTick, 1'b0, 1);
    steady = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int unsigned pick;
    int unsigned run;
    bit          stall_now;
    forever begin
      if (hold_req) begin
        // long hold-off so a waiting word backs up the input
        hold_req = 1'b0;
        stall_now = 1'b1;
        run = HoldCycles;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          stall_now = 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 65) begin
          stall_now = 1'b0;
          run = $urandom_range(30, 150);
        end else if (pick < 95) begin
          stall_now = 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          stall_now = 1'b1;
          run = $urandom_range(20, 60);
        end
      end
      @(negedge clk);
      out_stall <= stall_now;
      repeat (run - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fail_count < MaxReports) begin
          $display("%0t: word with none expected, status %0d width %0d",
                   $time, out_word.status, out_word.width_us);
        end
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.status != want.status) begin
          if (fail_count < MaxReports) begin
            $display("%0t: status expected %0d got %0d",
                     $time, want.status, out_word.status);
          end
          fail_count++;
        end
        if (out_word.width_us != want.width_us) begin
          if (fail_count < MaxReports) begin
            $display("%0t: width_us expected %0d got %0d",
                     $time, want.width_us, out_word.width_us);
          end
          fail_count++;
        end
      end
    end
  end

endmodule
